### rtl/lfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lfs_pkg;

    localparam int SENSOR_W = 5;
    localparam int SPEED_W  = 6;
    localparam int TICK_W   = 16;
    localparam int LAST_W   = 5;
    localparam int SUM_W    = 7;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SENSOR_W-1:0] CENTRE_ONLY  = 5'b00100;
    localparam logic [SENSOR_W-1:0] STOP_PATTERN = 5'b11011;

    localparam logic [TICK_W-1:0] CHANGE_TICKS_RESET = 16'd500;
    localparam logic [TICK_W-1:0] TICK_MAX           = 16'hFFFF;

    localparam logic [SUM_W-1:0] W_LOW  = 7'd4;
    localparam logic [SUM_W-1:0] W_MID  = 7'd12;
    localparam logic [SUM_W-1:0] W_FULL = 7'd16;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 6'sd16;
    localparam logic signed [SPEED_W-1:0] SPEED_BACK = -6'sd8;
    localparam logic signed [SPEED_W-1:0] SPEED_ZERO = 6'sd0;

    typedef enum logic [1:0] {
        DIR_CENTRE = 2'd0,
        DIR_LEFT   = 2'd1,
        DIR_RIGHT  = 2'd2,
        DIR_STOP   = 2'd3
    } dir_t;

    typedef logic signed [SPEED_W-1:0] speed_t;

    typedef struct packed {
        dir_t               direction;
        logic [TICK_W-1:0]  tick_count;
        logic [LAST_W-1:0]  last_left;
        logic [LAST_W-1:0]  last_right;
        logic               waiting_centre;
    } steer_state_t;

    typedef struct packed {
        dir_t   direction;
        logic   stop_both;
        logic   right_write;
        logic   left_write;
        speed_t right_speed;
        speed_t left_speed;
    } steer_result_t;

    localparam steer_state_t STATE_RESET = '{
        direction:      DIR_STOP,
        tick_count:     '0,
        last_left:      '0,
        last_right:     '0,
        waiting_centre: 1'b0
    };

endpackage

`default_nettype wire

### rtl/lfs_steer.sv
`timescale 1ns / 1ps
`default_nettype none

module lfs_steer (
    input  wire logic [lfs_pkg::SENSOR_W-1:0] sensor_bits,
    input  wire logic [lfs_pkg::TICK_W-1:0]   change_ticks,
    input  wire lfs_pkg::steer_state_t        state_cur,
    output lfs_pkg::steer_state_t             state_next,
    output lfs_pkg::steer_result_t            result,
    output logic                              has_result
);
    import lfs_pkg::*;

    logic [TICK_W-1:0] tick_inc;
    logic              early;
    logic [SUM_W-1:0]  ls_sum;
    logic [SUM_W-1:0]  rs_sum;
    speed_t            ls_sat;
    speed_t            rs_sat;
    speed_t            ls;
    speed_t            rs;
    speed_t            piv_ls;
    speed_t            piv_rs;
    dir_t              dir_present;
    dir_t              dir_lost;
    dir_t              dir_new;
    logic              line_present;
    logic              stop_now;
    logic              wl;
    logic              wr;

    always_comb begin
        tick_inc = (state_cur.tick_count < TICK_MAX) ? state_cur.tick_count + 16'd1
                                                     : state_cur.tick_count;
        early    = tick_inc < change_ticks;

        ls_sum = (sensor_bits[0] ? W_LOW : '0)
               + (sensor_bits[1] ? (early ? W_MID : W_LOW) : '0)
               + (sensor_bits[2] ? W_FULL : '0)
               + (sensor_bits[3] ? (early ? W_LOW : W_MID) : '0)
               + (sensor_bits[4] ? W_FULL : '0);
        rs_sum = (sensor_bits[0] ? W_FULL : '0)
               + (sensor_bits[1] ? (early ? W_LOW : W_MID) : '0)
               + (sensor_bits[2] ? W_FULL : '0)
               + (sensor_bits[3] ? (early ? W_MID : W_LOW) : '0)
               + (sensor_bits[4] ? W_LOW : '0);
        ls_sat = (ls_sum > W_FULL) ? SPEED_MAX : speed_t'(ls_sum[SPEED_W-1:0]);
        rs_sat = (rs_sum > W_FULL) ? SPEED_MAX : speed_t'(rs_sum[SPEED_W-1:0]);

        if (sensor_bits == STOP_PATTERN) begin
            dir_present = DIR_STOP;
        end else if (sensor_bits[4] || sensor_bits[3]) begin
            dir_present = DIR_RIGHT;
        end else if (sensor_bits[2]) begin
            dir_present = DIR_CENTRE;
        end else begin
            dir_present = DIR_LEFT;
        end

        if (sensor_bits[4]) begin
            dir_lost = DIR_RIGHT;
        end else if (sensor_bits[0]) begin
            dir_lost = DIR_LEFT;
        end else if (sensor_bits[2]) begin
            dir_lost = DIR_CENTRE;
        end else begin
            dir_lost = state_cur.direction;
        end

        case (state_cur.direction)
            DIR_LEFT: begin
                piv_ls = SPEED_BACK;
                piv_rs = SPEED_MAX;
            end
            DIR_RIGHT: begin
                piv_ls = SPEED_MAX;
                piv_rs = SPEED_BACK;
            end
            default: begin
                piv_ls = SPEED_ZERO;
                piv_rs = SPEED_ZERO;
            end
        endcase

        line_present = (sensor_bits != '0) && (state_cur.direction != DIR_STOP);
        stop_now     = !state_cur.waiting_centre && !line_present
                       && (state_cur.direction == DIR_CENTRE
                           || state_cur.direction == DIR_STOP)
                       && (tick_inc > change_ticks);

        state_next = state_cur;
        has_result = 1'b1;
        ls         = piv_ls;
        rs         = piv_rs;
        dir_new    = dir_lost;

        if (state_cur.waiting_centre) begin
            has_result = (sensor_bits == CENTRE_ONLY);
            state_next.waiting_centre = !has_result;
        end else begin
            state_next.tick_count = tick_inc;
            if (line_present) begin
                ls      = ls_sat;
                rs      = rs_sat;
                dir_new = dir_present;
            end
        end

        wl = ls[LAST_W-1:0] != state_cur.last_left;
        wr = rs[LAST_W-1:0] != state_cur.last_right;

        if (stop_now) begin
            state_next.waiting_centre = 1'b1;
            result.left_speed  = SPEED_ZERO;
            result.right_speed = SPEED_ZERO;
            result.left_write  = 1'b0;
            result.right_write = 1'b0;
            result.stop_both   = 1'b1;
            result.direction   = state_cur.direction;
        end else begin
            if (has_result) begin
                state_next.direction  = dir_new;
                state_next.last_left  = ls[LAST_W-1:0];
                state_next.last_right = rs[LAST_W-1:0];
                if (wl || wr) begin
                    state_next.tick_count = '0;
                end
            end
            result.left_speed  = ls;
            result.right_speed = rs;
            result.left_write  = wl;
            result.right_write = wr;
            result.stop_both   = 1'b0;
            result.direction   = dir_new;
        end
    end

endmodule

`default_nettype wire

### rtl/line_follower_steering.sv
`timescale 1ns / 1ps
`default_nettype none

// Line-follower steering. Each item on the s_ channel is one 5-bit line-sensor
// sample; each item on the m_ channel is a pair of motor commands with change
// flags, a stop flag and the direction state. A sample enters an input
// register, the steering logic and the direction/tick/last-command state are
// evaluated combinationally, and the result lands in an output register: one
// item per cycle sustained unless m_tready stalls the output. Samples taken
// while waiting for the centre-only pattern, other than it, give no result.
// Write change_ticks (reset 500) only while the block is idle.
module line_follower_steering (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [4:0] sensor_bits, [7:5] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [5:0] left_speed, [11:6] right_speed,
                                        // [12] left_write, [13] right_write,
                                        // [14] stop_both, [16:15] direction_state,
                                        // [23:17] zero
);
    import lfs_pkg::*;

    logic [TICK_W-1:0]   change_ticks_reg;
    logic                in_valid_reg;
    logic [SENSOR_W-1:0] in_bits_reg;
    steer_state_t        state_reg;
    steer_state_t        state_next;
    steer_result_t       result;
    steer_result_t       out_reg;
    logic                out_valid_reg;
    logic                has_result;
    logic                fire;

    lfs_steer u_steer (
        .sensor_bits  (in_bits_reg),
        .change_ticks (change_ticks_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .result       (result),
        .has_result   (has_result)
    );

    assign fire     = in_valid_reg && (!has_result || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            change_ticks_reg <= CHANGE_TICKS_RESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            state_reg        <= STATE_RESET;
        end else begin
            if (cfg_wr_en) begin
                change_ticks_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire && has_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (fire) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_bits_reg <= s_tdata[SENSOR_W-1:0];
        end
        if (fire && has_result) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg};

endmodule

`default_nettype wire

### rtl/lfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lfs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[13:0] == 14'd0)
        else $error("stop item with nonzero speed or write flag");

    a_stop_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[14] |-> m_tdata[16:15] == 2'd0 || m_tdata[16:15] == 2'd3)
        else $error("stop item from a pivot direction");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[5:0]) <= 6'sd16 && $signed(m_tdata[5:0]) >= -6'sd8
                  && $signed(m_tdata[11:6]) <= 6'sd16 && $signed(m_tdata[11:6]) >= -6'sd8)
        else $error("speed out of range");

endmodule

bind line_follower_steering lfs_checker u_lfs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
